[rtl/positional_insert_delete_array_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the positional insert/delete array
// Clocked on aclk; the checked form is disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define PIDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define PIDA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/pida_pkg.sv]
// ----------------------------------------------------------------------------
// pida_pkg
// Shared constants and types of the positional insert/delete array.
// ----------------------------------------------------------------------------
package pida_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int ELEM_WIDTH_DEFAULT = 32;

    // fixed field widths
    localparam int CMD_W   = 2;
    localparam int POS_W   = 4;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int LEN_W   = 5;
    localparam int LIMIT_W = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // wide enough for any index or count up to the largest depth
    localparam int IDX_W = 10;

    // APB
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_CAPACITY_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // commands
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             mdf;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] cnt;
    } pida_bcast_t;

endpackage

[rtl/pida_cell.sv]
// ----------------------------------------------------------------------------
// pida_cell
// One entry of the array: decides from the broadcast command whether to hold,
// load the new value, or take the neighbor entry below or above.
// ----------------------------------------------------------------------------
module pida_cell #(
    parameter int IDX        = 0,
    parameter int ELEM_WIDTH = pida_pkg::ELEM_WIDTH_DEFAULT
) (
    input  logic                  aclk,
    input  pida_pkg::pida_bcast_t bcast,
    input  logic [ELEM_WIDTH-1:0] new_data,
    input  logic [ELEM_WIDTH-1:0] below_data,
    input  logic [ELEM_WIDTH-1:0] above_data,
    output logic [ELEM_WIDTH-1:0] data
);

    localparam logic [pida_pkg::IDX_W-1:0] MY_IDX = pida_pkg::IDX_W'(IDX);

    logic [ELEM_WIDTH-1:0]        data_reg;
    logic [ELEM_WIDTH-1:0]        data_next;
    logic [pida_pkg::IDX_W-1:0]   my_idx_p1;

    assign my_idx_p1 = MY_IDX + pida_pkg::IDX_W'(1);

    always_comb begin
        data_next = data_reg;
        priority if ((bcast.ins || bcast.mdf) && MY_IDX == bcast.pos) begin
            data_next = new_data;
        end else if (bcast.ins && MY_IDX > bcast.pos && MY_IDX <= bcast.cnt) begin
            data_next = below_data;
        end else if (bcast.del && MY_IDX >= bcast.pos && my_idx_p1 < bcast.cnt) begin
            data_next = above_data;
        end else begin
            data_next = data_reg;
        end
    end

    // payload only, no reset
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/positional_insert_delete_array.sv]
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Ordered store of entries with a length count, edited by position.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one command word: s_tuser is the command (insert,
//   modify, delete, read), s_tdata holds position and value. m_ channel
//   returns one result word per command: m_tuser is the status (ok, invalid
//   position, full), m_tdata holds the value read and the new length.
//   The result is registered, valid in the cycle after acceptance. Throughput
//   is one command per cycle: every entry sits in its own cell of a row, and
//   an insert or delete moves all cells one place in the same clock edge, so
//   the length register is the only state carried from one command to the
//   next. The result register frees as it is taken, so s_tready stays high
//   while the receiver keeps up; when m_tready drops, the pending result is
//   held and s_tready falls until it is taken. Reset clears the length and
//   the result valid flag and sets the capacity limit to its full value;
//   entry contents are left as they are and are never visible before being
//   written. The user must write capacity_limit (APB offset 0) only while
//   the block is idle; it is not enforced. Values above DEPTH act as DEPTH.
// ----------------------------------------------------------------------------
module positional_insert_delete_array #(
    parameter int DEPTH      = pida_pkg::DEPTH_DEFAULT,
    parameter int ELEM_WIDTH = pida_pkg::ELEM_WIDTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // command words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pida_pkg::S_TDATA_W-1:0]  s_tdata,   // [3:0] position, [35:4] value
    input  logic [pida_pkg::CMD_W-1:0]      s_tuser,   // [1:0] command

    // result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pida_pkg::M_TDATA_W-1:0]  m_tdata,   // [31:0] read_value, [36:32] length
    output logic [pida_pkg::ST_W-1:0]       m_tuser,   // [1:0] status

    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pida_pkg::APB_AW-1:0]     paddr,
    input  logic [pida_pkg::APB_DW-1:0]     pwdata,
    output logic [pida_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = (ELEM_WIDTH > pida_pkg::VAL_W) ? ELEM_WIDTH : pida_pkg::VAL_W;
    localparam logic [pida_pkg::IDX_W-1:0] DEPTH_IDX = pida_pkg::IDX_W'(DEPTH);

    // ---------------- configuration ----------------
    logic [pida_pkg::LIMIT_W-1:0] limit_reg;
    logic                         cfg_wr;
    logic                         reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == pida_pkg::REG_CAPACITY_LIMIT);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? pida_pkg::APB_DW'(limit_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= pida_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            limit_reg <= pwdata[pida_pkg::LIMIT_W-1:0];
        end
    end

    // ---------------- command decode ----------------
    logic [pida_pkg::CMD_W-1:0] cmd;
    logic [pida_pkg::POS_W-1:0] pos;
    logic [RW-1:0]              val_wide;
    logic [ELEM_WIDTH-1:0]      val;
    logic [pida_pkg::IDX_W-1:0] pos_ext;
    logic [pida_pkg::IDX_W-1:0] cnt_ext;
    logic [pida_pkg::IDX_W-1:0] limit_ext;
    logic [pida_pkg::IDX_W-1:0] eff_limit;
    logic                       accept;

    assign cmd       = s_tuser;
    assign pos       = s_tdata[pida_pkg::POS_W-1:0];
    assign val_wide  = RW'(s_tdata[pida_pkg::POS_W +: pida_pkg::VAL_W]);
    assign val       = val_wide[ELEM_WIDTH-1:0];
    assign accept    = s_tvalid && s_tready;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign pos_ext   = pida_pkg::IDX_W'(pos);
    assign cnt_ext   = pida_pkg::IDX_W'(count_reg);
    assign limit_ext = pida_pkg::IDX_W'(limit_reg);
    // clamp the limit to the number of cells
    assign eff_limit = (limit_ext > DEPTH_IDX) ? DEPTH_IDX : limit_ext;

    logic [pida_pkg::ST_W-1:0] status;

    always_comb begin
        if (cmd == pida_pkg::CMD_INSERT) begin
            priority if (pos_ext > cnt_ext) begin
                status = pida_pkg::ST_BADPOS;
            end else if (cnt_ext >= eff_limit) begin
                status = pida_pkg::ST_FULL;
            end else begin
                status = pida_pkg::ST_OK;
            end
        end else begin
            status = (pos_ext >= cnt_ext) ? pida_pkg::ST_BADPOS : pida_pkg::ST_OK;
        end
    end

    // only successful commands reach the cells
    pida_pkg::pida_bcast_t bcast;
    logic                  cmd_ok;

    assign cmd_ok    = accept && (status == pida_pkg::ST_OK);
    assign bcast.ins = cmd_ok && (cmd == pida_pkg::CMD_INSERT);
    assign bcast.del = cmd_ok && (cmd == pida_pkg::CMD_DELETE);
    assign bcast.mdf = cmd_ok && (cmd == pida_pkg::CMD_MODIFY);
    assign bcast.pos = pos_ext;
    assign bcast.cnt = cnt_ext;

    // ---------------- row of cells ----------------
    logic [ELEM_WIDTH-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ELEM_WIDTH-1:0] below;
        logic [ELEM_WIDTH-1:0] above;
        if (i == 0) begin : g_bot
            assign below = val;
        end else begin : g_mid_lo
            assign below = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_top
            assign above = cell_data[i];
        end else begin : g_mid_hi
            assign above = cell_data[i+1];
        end
        pida_cell #(
            .IDX        (i),
            .ELEM_WIDTH (ELEM_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .bcast      (bcast),
            .new_data   (val),
            .below_data (below),
            .above_data (above),
            .data       (cell_data[i])
        );
    end

    // ---------------- length ----------------
    always_comb begin
        count_next = count_reg;
        if (bcast.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (bcast.del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // ---------------- read path ----------------
    logic [AW-1:0]              rd_idx;
    logic [RW-1:0]              rd_wide;
    logic [pida_pkg::VAL_W-1:0] rd_value;

    assign rd_idx   = pos_ext[AW-1:0];
    assign rd_wide  = RW'(cell_data[rd_idx]);
    // zero unless a read succeeds
    assign rd_value = (cmd_ok && cmd == pida_pkg::CMD_READ) ?
                      rd_wide[pida_pkg::VAL_W-1:0] : '0;

    // ---------------- result register ----------------
    logic                            m_tvalid_reg;
    logic                            m_tvalid_next;
    logic [pida_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic [pida_pkg::ST_W-1:0]       m_tuser_reg;

    // accept whenever the result register is empty or being drained
    assign s_tready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // hold the payload while the receiver stalls
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= pida_pkg::M_TDATA_W'({pida_pkg::LEN_W'(count_next), rd_value});
            m_tuser_reg <= status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[rtl/pida_checker.sv]
// ----------------------------------------------------------------------------
// pida_checker
// Port-level checks on the positional insert/delete array.
// ----------------------------------------------------------------------------
`include "positional_insert_delete_array_assert.svh"

module pida_checker #(
    parameter int DEPTH = pida_pkg::DEPTH_DEFAULT
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [pida_pkg::CMD_W-1:0]      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pida_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [pida_pkg::ST_W-1:0]       m_tuser
);

    localparam int LEN_LO = pida_pkg::VAL_W;

    logic [pida_pkg::LEN_W-1:0] len;
    logic [pida_pkg::VAL_W-1:0] rdv;

    assign len = m_tdata[LEN_LO +: pida_pkg::LEN_W];
    assign rdv = m_tdata[pida_pkg::VAL_W-1:0];

    // no result comes out of reset
    `PIDA_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "result valid after reset")

    // each accepted command gives a result in the next cycle
    `PIDA_ASSERT(a_latency, s_tvalid && s_tready |=> m_tvalid, "missing result word")

    // length never exceeds the number of cells
    `PIDA_ASSERT(a_len_max, m_tvalid |-> (32'(len) <= DEPTH), "length above depth")

    // a failed command reports no data
    `PIDA_ASSERT(a_rd_zero, m_tvalid && m_tuser != pida_pkg::ST_OK |-> rdv == '0,
                 "read value on failed command")

    // consecutive results: a read or modify leaves the length unchanged
    `PIDA_ASSERT(a_len_keep,
                 s_tvalid && s_tready && m_tvalid && m_tready &&
                 (s_tuser == pida_pkg::CMD_READ || s_tuser == pida_pkg::CMD_MODIFY)
                 |=> len == $past(len), "length changed by read or modify")

endmodule

bind positional_insert_delete_array pida_checker #(.DEPTH(DEPTH)) u_pida_checker (.*);

[tb/positional_insert_delete_array_tb.sv]
// ----------------------------------------------------------------------------
// positional_insert_delete_array_tb
// Self-checking bench for the positional insert/delete array. Command words
// go in on the s_ stream, and every result word on the m_ stream is compared
// with the oldest prediction of a shadow array model. A short directed table
// comes first, then random phases at several capacity limits, with random
// idling on both streams, one long receiver hold-off and one drained pause.
// ----------------------------------------------------------------------------
module positional_insert_delete_array_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH           = pida_pkg::DEPTH_DEFAULT;
    localparam int N_PHASES        = 10;
    localparam int PHASE_ITEMS     = 125;
    localparam int RX_HOLD_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam logic [pida_pkg::APB_AW-1:0] LIMIT_ADDR =
        pida_pkg::APB_AW'(4 * pida_pkg::REG_CAPACITY_LIMIT);

    // limit per random phase: reset value, extremes, oversized, and a few
    // in between; lowering it under the current length happens on the way
    localparam logic [pida_pkg::LIMIT_W-1:0] PHASE_LIMITS [N_PHASES] = '{
        5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd17, 5'd9, 5'd2, 5'd16
    };

    typedef struct packed {
        logic [pida_pkg::ST_W-1:0]  status;
        logic [pida_pkg::VAL_W-1:0] rd;
        logic [pida_pkg::LEN_W-1:0] len;
    } array_res_t;

    typedef struct packed {
        logic [pida_pkg::CMD_W-1:0] cmd;
        logic [pida_pkg::POS_W-1:0] pos;
        logic [pida_pkg::VAL_W-1:0] val;
        logic                       typed;   // row carries its own expected result
        array_res_t                 res;
    } cmd_row_t;

    localparam int N_ROWS = 25;

    // directed commands, starting from reset (empty, limit 16)
    localparam cmd_row_t CMD_ROWS [N_ROWS] = '{
        '{pida_pkg::CMD_READ,   4'd0,  32'h0000_0000, 1'b1, '{pida_pkg::ST_BADPOS, 32'h0, 5'd0}},
        '{pida_pkg::CMD_MODIFY, 4'd0,  32'hFFFF_FFFF, 1'b1, '{pida_pkg::ST_BADPOS, 32'h0, 5'd0}},
        '{pida_pkg::CMD_DELETE, 4'd0,  32'h0000_0000, 1'b1, '{pida_pkg::ST_BADPOS, 32'h0, 5'd0}},
        '{pida_pkg::CMD_INSERT, 4'd1,  32'h0000_0001, 1'b1, '{pida_pkg::ST_BADPOS, 32'h0, 5'd0}},
        '{pida_pkg::CMD_INSERT, 4'd0,  32'hFFFF_FFFF, 1'b1, '{pida_pkg::ST_OK, 32'h0, 5'd1}},
        '{pida_pkg::CMD_READ,   4'd0,  32'h0000_0000, 1'b1,
          '{pida_pkg::ST_OK, 32'hFFFF_FFFF, 5'd1}},
        '{pida_pkg::CMD_INSERT, 4'd0,  32'h0000_0000, 1'b1, '{pida_pkg::ST_OK, 32'h0, 5'd2}},
        '{pida_pkg::CMD_INSERT, 4'd2,  32'hA5A5_A5A5, 1'b0, '0},
        '{pida_pkg::CMD_INSERT, 4'd1,  32'h5A5A_5A5A, 1'b0, '0},
        '{pida_pkg::CMD_READ,   4'd0,  32'h0000_0000, 1'b0, '0},
        '{pida_pkg::CMD_READ,   4'd1,  32'h0000_0000, 1'b0, '0},
        '{pida_pkg::CMD_READ,   4'd2,  32'h0000_0000, 1'b0, '0},
        '{pida_pkg::CMD_READ,   4'd3,  32'h0000_0000, 1'b0, '0},
        '{pida_pkg::CMD_READ,   4'd4,  32'h0000_0000, 1'b1, '{pida_pkg::ST_BADPOS, 32'h0, 5'd4}},
        '{pida_pkg::CMD_MODIFY, 4'd3,  32'h1234_5678, 1'b0, '0},
        '{pida_pkg::CMD_READ,   4'd3,  32'h0000_0000, 1'b0, '0},
        '{pida_pkg::CMD_DELETE, 4'd0,  32'h0000_0000, 1'b0, '0},
        '{pida_pkg::CMD_READ,   4'd0,  32'h0000_0000, 1'b0, '0},
        '{pida_pkg::CMD_DELETE, 4'd2,  32'h0000_0000, 1'b0, '0},
        '{pida_pkg::CMD_READ,   4'd2,  32'h0000_0000, 1'b1, '{pida_pkg::ST_BADPOS, 32'h0, 5'd2}},
        '{pida_pkg::CMD_INSERT, 4'd2,  32'hDEAD_BEEF, 1'b0, '0},
        '{pida_pkg::CMD_READ,   4'd2,  32'h0000_0000, 1'b0, '0},
        '{pida_pkg::CMD_INSERT, 4'd15, 32'h0000_0000, 1'b1, '{pida_pkg::ST_BADPOS, 32'h0, 5'd3}},
        '{pida_pkg::CMD_MODIFY, 4'd15, 32'hFFFF_FFFF, 1'b1, '{pida_pkg::ST_BADPOS, 32'h0, 5'd3}},
        '{pida_pkg::CMD_DELETE, 4'd1,  32'h0000_0000, 1'b0, '0}
    };

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [pida_pkg::S_TDATA_W-1:0]      s_tdata;   // [3:0] position, [35:4] value
    logic [pida_pkg::CMD_W-1:0]          s_tuser;   // [1:0] command
    logic                                m_tvalid;
    logic                                m_tready;
    logic [pida_pkg::M_TDATA_W-1:0]      m_tdata;   // [31:0] read_value, [36:32] length
    logic [pida_pkg::ST_W-1:0]           m_tuser;   // [1:0] status
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [pida_pkg::APB_AW-1:0]         paddr;
    logic [pida_pkg::APB_DW-1:0]         pwdata;
    logic [pida_pkg::APB_DW-1:0]         prdata;
    logic                                pready;

    // shadow copy of the array, its length and the limit register
    logic [pida_pkg::VAL_W-1:0]   entry_model [DEPTH];
    int                           len_model   = 0;
    logic [pida_pkg::LIMIT_W-1:0] limit_model = pida_pkg::LIMIT_RESET;

    array_res_t pending_results [$];
    int         err_cnt     = 0;
    int         idle_cycles = 0;

    // handoff from the sender to the scoreboard for the word on the bus
    bit         row_typed = 1'b0;
    array_res_t row_res   = '0;

    // idling control shared by both streams
    bit no_idle      = 1'b0;
    bit rx_hold_req  = 1'b0;
    int burst_left   = 0;

    positional_insert_delete_array u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    // Apply one command to the shadow array and return the result word it
    // must produce. Insert checks the position before fullness; the other
    // commands need a position below the length and change nothing if not.
    function automatic array_res_t edit_array(logic [pida_pkg::CMD_W-1:0] cmd,
                                              logic [pida_pkg::POS_W-1:0] pos,
                                              logic [pida_pkg::VAL_W-1:0] val);
        array_res_t r;
        int         lim;
        int         i;
        r   = '0;
        lim = (int'(limit_model) > DEPTH) ? DEPTH : int'(limit_model);
        if (cmd == pida_pkg::CMD_INSERT) begin
            if (int'(pos) > len_model) begin
                r.status = pida_pkg::ST_BADPOS;
            end else if (len_model >= lim) begin
                r.status = pida_pkg::ST_FULL;
            end else begin
                for (i = len_model; i > int'(pos); i--)
                    entry_model[i] = entry_model[i-1];
                entry_model[pos] = val;
                len_model++;
            end
        end else if (int'(pos) >= len_model) begin
            r.status = pida_pkg::ST_BADPOS;
        end else begin
            case (cmd)
                pida_pkg::CMD_MODIFY: begin
                    entry_model[pos] = val;
                end
                pida_pkg::CMD_DELETE: begin
                    // the vacated top slot keeps stale bits; it is never read
                    for (i = int'(pos); i + 1 < len_model; i++)
                        entry_model[i] = entry_model[i+1];
                    len_model--;
                end
                pida_pkg::CMD_READ: begin
                    r.rd = entry_model[pos];
                end
                default: begin
                end
            endcase
        end
        r.len = pida_pkg::LEN_W'(len_model);
        return r;
    endfunction

    function automatic int pick_gap();
        if (no_idle || burst_left > 0)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    // Offer one command word; hold it until the block takes it.
    task automatic send_word(logic [pida_pkg::CMD_W-1:0] cmd,
                             logic [pida_pkg::POS_W-1:0] pos,
                             logic [pida_pkg::VAL_W-1:0] val,
                             bit typed, array_res_t res);
        int gap;
        gap = pick_gap();
        if (burst_left > 0)
            burst_left--;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid  <= 1'b1;
        s_tdata   <= {{(pida_pkg::S_TDATA_W-pida_pkg::VAL_W-pida_pkg::POS_W){1'b0}},
                      val, pos};
        s_tuser   <= cmd;
        row_typed = typed;
        row_res   = res;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    // Drop the offer and wait until every predicted word has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Write the capacity limit over APB, then read it back.
    task automatic set_limit(logic [pida_pkg::LIMIT_W-1:0] lim);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= pida_pkg::APB_DW'(lim);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        limit_model = lim;
        // turn straight into the read setup phase
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[pida_pkg::LIMIT_W-1:0] !== lim) begin
            $error("capacity_limit readback: expected %0d, got %0d",
                   lim, prdata[pida_pkg::LIMIT_W-1:0]);
            err_cnt++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Scoreboard: retire the result word first, then predict the command
    // word taken on the same edge, so a stray result never eats a fresh
    // prediction.
    always @(posedge aclk) begin : scoreboard
        array_res_t got;
        array_res_t want;
        array_res_t pred;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.rd     = m_tdata[pida_pkg::VAL_W-1:0];
                got.len    = m_tdata[pida_pkg::VAL_W +: pida_pkg::LEN_W];
                if (pending_results.size() == 0) begin
                    $error("result word with nothing expected: status %0d len %0d",
                           got.status, got.len);
                    err_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        err_cnt++;
                    end
                    if (got.rd !== want.rd) begin
                        $error("read_value: expected %h, got %h", want.rd, got.rd);
                        err_cnt++;
                    end
                    if (got.len !== want.len) begin
                        $error("length: expected %0d, got %0d", want.len, got.len);
                        err_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                // advance the shadow array even for rows with typed results
                pred = edit_array(s_tuser, s_tdata[pida_pkg::POS_W-1:0],
                                  s_tdata[pida_pkg::POS_W +: pida_pkg::VAL_W]);
                pending_results.push_back(row_typed ? row_res : pred);
            end
        end
    end

    // Watchdog: count cycles with no word moving on either stream and no
    // APB access in flight.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Result sink: draw a wait before each word; a hold request from the
    // sender replaces one draw with a long stretch of m_tready low.
    initial begin : result_sink
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold_req) begin
                gap         = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end else begin
                gap = pick_gap();
            end
            repeat (gap) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Main stimulus: reset, directed table, then random phases.
    initial begin : stimulus
        int                         mode;
        int                         r;
        int                         hi;
        int                         ins_w;
        int                         mod_w;
        int                         del_w;
        logic [pida_pkg::CMD_W-1:0] c;
        logic [pida_pkg::POS_W-1:0] p;
        logic [pida_pkg::VAL_W-1:0] v;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = pida_pkg::CMD_INSERT;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        for (int i = 0; i < DEPTH; i++)
            entry_model[i] = '0;

        // hold reset, then release it on a falling edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table at the reset limit
        for (int k = 0; k < N_ROWS; k++)
            send_word(CMD_ROWS[k].cmd, CMD_ROWS[k].pos, CMD_ROWS[k].val,
                      CMD_ROWS[k].typed, CMD_ROWS[k].res);

        mode = 0;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            // reprogram the limit only with the pipeline empty
            drain_results();
            set_limit(PHASE_LIMITS[ph]);
            no_idle = ($urandom_range(0, 3) == 0);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2)
                    no_idle = ($urandom_range(0, 3) == 0);

                // stall the sink for a long stretch while words keep coming
                if (ph == 4 && n == 10) begin
                    rx_hold_req = 1'b1;
                    burst_left  = RX_HOLD_CYCLES + 10;
                end

                // pause the source until every result is back
                if (ph == 7 && n == 60)
                    drain_results();

                // swing between filling, emptying and mixed traffic so the
                // length sweeps the whole range under each limit
                if (n % 25 == 0)
                    mode = $urandom_range(0, 2);
                case (mode)
                    0:       begin ins_w = 55; mod_w = 70; del_w = 80; end
                    1:       begin ins_w = 15; mod_w = 30; del_w = 75; end
                    default: begin ins_w = 30; mod_w = 50; del_w = 70; end
                endcase
                r = $urandom_range(0, 99);
                if (r < ins_w)
                    c = pida_pkg::CMD_INSERT;
                else if (r < mod_w)
                    c = pida_pkg::CMD_MODIFY;
                else if (r < del_w)
                    c = pida_pkg::CMD_DELETE;
                else
                    c = pida_pkg::CMD_READ;

                // mostly in-range positions, some noise over the full field
                if ($urandom_range(0, 9) == 0) begin
                    p = pida_pkg::POS_W'($urandom_range(0, 15));
                end else if (c == pida_pkg::CMD_INSERT) begin
                    hi = (len_model > 15) ? 15 : len_model;
                    p  = pida_pkg::POS_W'($urandom_range(0, hi));
                end else if (len_model == 0) begin
                    p = pida_pkg::POS_W'($urandom_range(0, 15));
                end else begin
                    p = pida_pkg::POS_W'($urandom_range(0, len_model - 1));
                end

                r = $urandom_range(0, 15);
                if (r == 0)
                    v = '0;
                else if (r == 1)
                    v = '1;
                else
                    v = $urandom();

                send_word(c, p, v, 1'b0, '0);
            end
        end

        drain_results();
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
